// ----- design/sum_checked_frame_parser_macros.svh -----
// ----------------------------------------------------------------------------
// Frame parser assertion macros
// Shared property wrappers, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SUM_CHECKED_FRAME_PARSER_MACROS_SVH
`define SUM_CHECKED_FRAME_PARSER_MACROS_SVH

// Same-cycle implication
`define SCFP_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define SCFP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/scfp_pkg.sv -----
// ----------------------------------------------------------------------------
// Frame parser package
// Parser phases, framing constants, register indexes and result type.
// ----------------------------------------------------------------------------
package scfp_pkg;

   // Parser phase
   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_SYNC1   = 3'd1,
      PH_SYNC2   = 3'd2,
      PH_TYPE    = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_CHECK   = 3'd5
   } phase_type;

   // Framing bytes
   localparam logic [7:0] SYNC_BYTE_0 = 8'hFF;
   localparam logic [7:0] SYNC_BYTE_1 = 8'hFB;
   localparam logic [7:0] TYPE_LIMIT  = 8'hF1;

   // Configuration register indexes
   typedef enum logic [1:0] {
      REG_EXPECTED_TYPE = 2'd0,
      REG_MIN_LENGTH    = 2'd1,
      REG_MAX_LENGTH    = 2'd2,
      REG_TIMEOUT_LIMIT = 2'd3
   } reg_index_type;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 16;

   // Register reset values
   localparam logic [7:0]  EXPECTED_TYPE_RST = 8'd26;
   localparam logic [7:0]  MIN_LENGTH_RST    = 8'd50;
   localparam logic [7:0]  MAX_LENGTH_RST    = 8'd150;
   localparam logic [15:0] TIMEOUT_LIMIT_RST = 16'd1000;

   // Result kind and verdict codes
   localparam logic      KIND_PAYLOAD = 1'b0;
   localparam logic      KIND_END     = 1'b1;
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_SUM_ERR  = 2'd1;
   localparam logic [1:0] STATUS_TYPE_ERR = 2'd2;

   // One result item
   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
      logic [7:0] byte_index;
      logic [7:0] frame_type;
      logic [1:0] status;
   } result_type;

endpackage

// ----- design/scfp_channels.sv -----
// ----------------------------------------------------------------------------
// Frame parser channels
// Valid/ready interfaces for received bytes and parser results.
// ----------------------------------------------------------------------------

// Received byte channel
interface scfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// Result channel
interface scfp_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] data_byte;
   logic [7:0] byte_index;
   logic [7:0] frame_type;
   logic [1:0] status;

   modport source (output valid, output kind, output data_byte, output byte_index,
                   output frame_type, output status, input ready);
   modport sink   (input valid, input kind, input data_byte, input byte_index,
                   input frame_type, input status, output ready);
endinterface

// ----- design/sum_checked_frame_parser.sv -----
// ----------------------------------------------------------------------------
// sum_checked_frame_parser: result registered from each taken request, 1 request per cycle
// while the result register is empty or being drained; the receiver frees the result register.
// Synchronous active-high reset: idle phase, empty result, registers at defaults.
// ----------------------------------------------------------------------------
`include "sum_checked_frame_parser_macros.svh"

module sum_checked_frame_parser (
   input  logic                              clock,
   input  logic                              reset,
   scfp_req_if.sink                          req_bus,
   scfp_rsp_if.source                        rsp_bus,
   input  logic                              csr_we,
   input  logic [scfp_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [scfp_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import scfp_pkg::*;

   // Configuration registers
   logic [7:0]  expected_type_ff;
   logic [7:0]  min_length_ff;
   logic [7:0]  max_length_ff;
   logic [15:0] timeout_limit_ff;

   // Parser state
   phase_type   phase_ff, phase_in;
   logic [7:0]  bytes_left_ff, bytes_left_in;
   logic [7:0]  payload_count_ff, payload_count_in;
   logic [7:0]  running_sum_ff, running_sum_in;
   logic [7:0]  held_type_ff, held_type_in;
   logic [16:0] stall_count_ff, stall_count_in;

   // Result register
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_data_ff;

   // Step signals
   logic        req_fire;
   logic        res_valid;
   result_type  res_data;
   logic [7:0]  rx;
   logic [16:0] stall_inc;
   logic        timed_out;
   phase_type   cur_phase;
   logic [7:0]  bytes_dec;

   // Accept while the result register is empty or being drained
   assign req_bus.ready = ~rsp_valid_ff | rsp_bus.ready;
   assign req_fire      = req_bus.valid & req_bus.ready;
   assign rx            = req_bus.rx_byte;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         expected_type_ff <= EXPECTED_TYPE_RST;
         min_length_ff    <= MIN_LENGTH_RST;
         max_length_ff    <= MAX_LENGTH_RST;
         timeout_limit_ff <= TIMEOUT_LIMIT_RST;
      end else if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_EXPECTED_TYPE: expected_type_ff <= csr_wdata[7:0];
            REG_MIN_LENGTH:    min_length_ff    <= csr_wdata[7:0];
            REG_MAX_LENGTH:    max_length_ff    <= csr_wdata[7:0];
            REG_TIMEOUT_LIMIT: timeout_limit_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Apply the stall timeout before handling the byte
   assign stall_inc = stall_count_ff + 17'd1;
   assign timed_out = stall_inc > {1'b0, timeout_limit_ff};
   assign cur_phase = timed_out ? PH_IDLE : phase_ff;
   assign bytes_dec = bytes_left_ff - 8'd1;

   // Parse step
   always_comb begin
      phase_in         = cur_phase;
      bytes_left_in    = bytes_left_ff;
      payload_count_in = payload_count_ff;
      running_sum_in   = running_sum_ff;
      held_type_in     = held_type_ff;
      stall_count_in   = timed_out ? 17'd0 : stall_inc;
      res_valid        = 1'b0;
      res_data         = '{kind: KIND_PAYLOAD, data_byte: rx, byte_index: payload_count_ff,
                           frame_type: held_type_ff, status: STATUS_OK};

      priority if (cur_phase == PH_IDLE && rx == SYNC_BYTE_0) begin
         phase_in       = PH_SYNC1;
         running_sum_in = SYNC_BYTE_0;
         stall_count_in = '0;
      end else if (cur_phase == PH_SYNC1 && rx == SYNC_BYTE_1) begin
         phase_in       = PH_SYNC2;
         running_sum_in = running_sum_ff + rx;
         stall_count_in = '0;
      end else if (cur_phase == PH_SYNC1 && rx == SYNC_BYTE_0) begin
         running_sum_in = SYNC_BYTE_0;
         stall_count_in = '0;
      end else if (cur_phase == PH_SYNC2 && rx != 8'd0 && rx < TYPE_LIMIT) begin
         phase_in       = PH_TYPE;
         held_type_in   = rx;
         running_sum_in = running_sum_ff + rx;
         stall_count_in = '0;
      end else if (cur_phase == PH_TYPE) begin
         stall_count_in = '0;
         if (rx < min_length_ff || rx > max_length_ff) begin
            phase_in = PH_IDLE;
         end else begin
            phase_in         = PH_PAYLOAD;
            bytes_left_in    = rx;
            payload_count_in = '0;
            running_sum_in   = running_sum_ff + rx;
         end
      end else if (cur_phase == PH_PAYLOAD && bytes_left_ff != 8'd0) begin
         res_valid        = 1'b1;
         bytes_left_in    = bytes_dec;
         payload_count_in = payload_count_ff + 8'd1;
         running_sum_in   = running_sum_ff + rx;
         if (bytes_dec == 8'd0) begin
            phase_in       = PH_CHECK;
            stall_count_in = '0;
         end
      end else if (cur_phase == PH_CHECK) begin
         res_valid           = 1'b1;
         res_data.kind       = KIND_END;
         res_data.byte_index = '0;
         if (running_sum_ff != rx) begin
            res_data.status = STATUS_SUM_ERR;
         end else if (held_type_ff != expected_type_ff) begin
            res_data.status = STATUS_TYPE_ERR;
         end else begin
            res_data.status = STATUS_OK;
         end
         phase_in       = PH_IDLE;
         stall_count_in = '0;
      end else begin
         // Stray byte: re-arm on a sync byte, else drop to idle
         if (rx == SYNC_BYTE_0) begin
            phase_in       = PH_SYNC1;
            running_sum_in = SYNC_BYTE_0;
         end else begin
            phase_in = PH_IDLE;
         end
      end
   end

   // Advance parser state on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         bytes_left_ff    <= '0;
         payload_count_ff <= '0;
         running_sum_ff   <= '0;
         held_type_ff     <= '0;
         stall_count_ff   <= '0;
      end else if (req_fire) begin
         phase_ff         <= phase_in;
         bytes_left_ff    <= bytes_left_in;
         payload_count_ff <= payload_count_in;
         running_sum_ff   <= running_sum_in;
         held_type_ff     <= held_type_in;
         stall_count_ff   <= stall_count_in;
      end
   end

   // Result register: load on accept, hold while stalled
   assign rsp_valid_in = req_bus.ready ? (req_fire & res_valid) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && res_valid) begin
         rsp_data_ff <= res_data;
      end
   end

   // Drive the result channel
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.kind       = rsp_data_ff.kind;
   assign rsp_bus.data_byte  = rsp_data_ff.data_byte;
   assign rsp_bus.byte_index = rsp_data_ff.byte_index;
   assign rsp_bus.frame_type = rsp_data_ff.frame_type;
   assign rsp_bus.status     = rsp_data_ff.status;

   // Checks
   `SCFP_ASSERT_IMPLY(a_rsp_from_req, $rose(rsp_valid_ff), $past(req_fire), "result without request")
   `SCFP_ASSERT_IMPLY(a_payload_status, rsp_valid_ff && rsp_data_ff.kind == KIND_PAYLOAD,
                      rsp_data_ff.status == STATUS_OK, "payload result with verdict")
   `SCFP_ASSERT_IMPLY(a_end_index, rsp_valid_ff && rsp_data_ff.kind == KIND_END,
                      rsp_data_ff.byte_index == 8'd0, "end result with index")
   `SCFP_ASSERT_NEXT(a_idle_stray, req_fire && phase_ff == PH_IDLE && rx != SYNC_BYTE_0,
                     phase_ff == PH_IDLE, "stray byte left idle")

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame parser testbench
// Feeds received bytes to the frame parser through its request channel and
// checks every payload and end-of-frame result against an in-bench parse
// model. A short scripted pass covers header rejects and two short frames,
// then randomized traffic runs under several register settings, including
// zero length, single length, 255-byte payloads, crossed limits and tiny
// timeouts, with random gaps, one long result hold-off and drained phases.
// ----------------------------------------------------------------------------
module testbench;
   import scfp_pkg::*;

   // Result hold-off length, drain after the last due result, run limit
   localparam int HOLD_CYCLES  = 48;
   localparam int DRAIN_CYCLES = 4;
   // About 1700 requests, each at worst a random gap plus a random stall,
   // plus hold-off and drains: the run limit leaves a wide margin over that
   localparam int CYCLE_LIMIT  = 400000;

   typedef enum logic {ROW_RX, ROW_CFG} row_kind_type;

   typedef struct {
      row_kind_type  kind;
      logic [7:0]    rx;
      bit            fixed;
      bit            has_rsp;
      result_type    rsp;
      reg_index_type idx;
      logic [15:0]   wdata;
   } script_row_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   scfp_req_if req_bus ();
   scfp_rsp_if rsp_bus ();

   sum_checked_frame_parser u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Parse model registers and state
   logic [7:0]  want_type  = EXPECTED_TYPE_RST;
   logic [7:0]  len_min    = MIN_LENGTH_RST;
   logic [7:0]  len_max    = MAX_LENGTH_RST;
   logic [15:0] idle_limit = TIMEOUT_LIMIT_RST;

   phase_type   parse_phase    = PH_IDLE;
   logic [7:0]  left_count     = '0;
   logic [7:0]  payload_pos    = '0;
   logic [7:0]  frame_sum      = '0;
   logic [7:0]  type_seen      = '0;
   logic [16:0] quiet_count    = '0;

   result_type      results_due[$];
   script_row_type  script[$];

   // Per-request tags set by the sender, read when the request is taken
   bit          row_fixed;
   bit          row_has_rsp;
   result_type  row_rsp;

   bit          idling_on;
   bit          rsp_hold_request;
   int          rx_sent;
   int          mismatch_count;
   int          cycle_count;

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Advance the parse model by one byte; return 1 when it yields a result
   function automatic bit parse_rx_byte(input logic [7:0] b, output result_type res);
      bit yields;
      yields = 1'b0;
      res = '0;
      quiet_count = quiet_count + 17'd1;
      if (quiet_count > {1'b0, idle_limit}) begin
         parse_phase = PH_IDLE;
         quiet_count = '0;
      end
      if (parse_phase == PH_IDLE && b == SYNC_BYTE_0) begin
         parse_phase = PH_SYNC1;
         frame_sum = SYNC_BYTE_0;
         quiet_count = '0;
      end else if (parse_phase == PH_SYNC1 && b == SYNC_BYTE_1) begin
         parse_phase = PH_SYNC2;
         frame_sum = frame_sum + b;
         quiet_count = '0;
      end else if (parse_phase == PH_SYNC1 && b == SYNC_BYTE_0) begin
         frame_sum = SYNC_BYTE_0;
         quiet_count = '0;
      end else if (parse_phase == PH_SYNC2 && b != 8'h00 && b < TYPE_LIMIT) begin
         parse_phase = PH_TYPE;
         type_seen = b;
         frame_sum = frame_sum + b;
         quiet_count = '0;
      end else if (parse_phase == PH_TYPE) begin
         quiet_count = '0;
         if (b < len_min || b > len_max) begin
            parse_phase = PH_IDLE;
         end else begin
            parse_phase = PH_PAYLOAD;
            left_count = b;
            payload_pos = '0;
            frame_sum = frame_sum + b;
         end
      end else if (parse_phase == PH_PAYLOAD && left_count != 8'h00) begin
         res = '{KIND_PAYLOAD, b, payload_pos, type_seen, STATUS_OK};
         yields = 1'b1;
         left_count = left_count - 8'd1;
         payload_pos = payload_pos + 8'd1;
         frame_sum = frame_sum + b;
         if (left_count == 8'h00) begin
            parse_phase = PH_CHECK;
            quiet_count = '0;
         end
      end else if (parse_phase == PH_CHECK) begin
         // Checksum verdict wins over the type verdict
         res = '{KIND_END, b, 8'h00, type_seen, STATUS_OK};
         if (frame_sum != b) begin
            res.status = STATUS_SUM_ERR;
         end else if (type_seen != want_type) begin
            res.status = STATUS_TYPE_ERR;
         end
         yields = 1'b1;
         parse_phase = PH_IDLE;
         quiet_count = '0;
      end else if (b == SYNC_BYTE_0) begin
         // Stray 0xFF re-arms the header
         parse_phase = PH_SYNC1;
         frame_sum = SYNC_BYTE_0;
      end else begin
         parse_phase = PH_IDLE;
      end
      return yields;
   endfunction

   task automatic flag_mismatch(input string what, input logic [7:0] got,
                                input logic [7:0] want);
      if (mismatch_count < 100) begin
         $display("%0t mismatch %s: got %0h, want %0h", $time, what, got, want);
      end
      mismatch_count++;
   endtask

   // Predict on each taken request, compare each taken result with the oldest due
   always @(posedge clock) begin : watch_channels
      result_type predicted;
      result_type due;
      bit         yields;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            yields = parse_rx_byte(req_bus.rx_byte, predicted);
            if (row_fixed) begin
               if (row_has_rsp) begin
                  results_due.push_back(row_rsp);
               end
            end else if (yields) begin
               results_due.push_back(predicted);
            end
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (results_due.size() == 0) begin
               flag_mismatch("result with nothing due, data_byte", rsp_bus.data_byte, 8'h00);
            end else begin
               due = results_due.pop_front();
               if (rsp_bus.kind !== due.kind) begin
                  flag_mismatch("kind", {7'd0, rsp_bus.kind}, {7'd0, due.kind});
               end
               if (rsp_bus.data_byte !== due.data_byte) begin
                  flag_mismatch("data_byte", rsp_bus.data_byte, due.data_byte);
               end
               if (rsp_bus.byte_index !== due.byte_index) begin
                  flag_mismatch("byte_index", rsp_bus.byte_index, due.byte_index);
               end
               if (rsp_bus.frame_type !== due.frame_type) begin
                  flag_mismatch("frame_type", rsp_bus.frame_type, due.frame_type);
               end
               if (rsp_bus.status !== due.status) begin
                  flag_mismatch("status", {6'd0, rsp_bus.status}, {6'd0, due.status});
               end
            end
         end
      end
   end

   // Watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("testbench: errors");
      $finish;
   end

   // Result receiver: random stalls, plus one long hold-off on request
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_request) begin
            rsp_hold_request = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 4) - 1) @(negedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Offer one byte, maybe after a gap, and hold it until taken
   task automatic send_rx(input logic [7:0] b, input bit fixed, input bit has_rsp,
                          input result_type rsp);
      if (idling_on && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      row_fixed = fixed;
      row_has_rsp = has_rsp;
      row_rsp = rsp;
      req_bus.valid <= 1'b1;
      req_bus.rx_byte <= b;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      rx_sent++;
      @(negedge clock);
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_rx(b, 1'b0, 1'b0, '0);
   endtask

   // Drop valid and wait until every due result has come and the block settles
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (results_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Write one register and mirror it; the caller drops csr_we afterwards
   task automatic csr_put(input reg_index_type idx, input logic [15:0] d);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      unique case (idx)
         REG_EXPECTED_TYPE: want_type = d[7:0];
         REG_MIN_LENGTH:    len_min = d[7:0];
         REG_MAX_LENGTH:    len_max = d[7:0];
         REG_TIMEOUT_LIMIT: idle_limit = d;
      endcase
      @(negedge clock);
   endtask

   // Mostly whole frames with random content, the rest broken headers and noise
   task automatic send_frame_or_noise();
      int         pick;
      int         len;
      int         cut;
      logic [7:0] ftype;
      logic [7:0] b;
      logic [7:0] sum;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         ftype = ($urandom_range(0, 9) < 6) ? want_type : 8'($urandom_range(1, 240));
         if (len_min <= len_max) begin
            len = $urandom_range(len_min, len_max);
         end else begin
            len = $urandom_range(0, 255);
         end
         // Now and then abandon the frame partway through
         cut = ($urandom_range(0, 11) == 0) ? $urandom_range(0, len) : len + 1;
         if ($urandom_range(0, 9) == 0) begin
            send_byte(SYNC_BYTE_0);
         end
         send_byte(SYNC_BYTE_0);
         send_byte(SYNC_BYTE_1);
         send_byte(ftype);
         send_byte(8'(len));
         sum = SYNC_BYTE_0 + SYNC_BYTE_1 + ftype + 8'(len);
         for (int k = 0; k < len; k++) begin
            if (k == cut) return;
            b = 8'($urandom_range(0, 255));
            sum = sum + b;
            send_byte(b);
         end
         if (cut == len) return;
         send_byte(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : sum);
      end else if (pick < 85) begin
         send_byte(SYNC_BYTE_0);
         case ($urandom_range(0, 3))
            0: begin
               send_byte(8'($urandom_range(0, 255)));
            end
            1: begin
               // Type byte out of range
               send_byte(SYNC_BYTE_1);
               send_byte(($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom_range(241, 255)));
            end
            2: begin
               // Length byte out of range
               send_byte(SYNC_BYTE_1);
               send_byte(8'($urandom_range(1, 240)));
               if (len_min > 8'd0) begin
                  send_byte(8'($urandom_range(0, len_min - 8'd1)));
               end else if (len_max < 8'd255) begin
                  send_byte(8'($urandom_range(len_max + 8'd1, 255)));
               end else begin
                  send_byte(8'($urandom_range(0, 255)));
               end
            end
            default: begin
               send_byte(SYNC_BYTE_0);
               send_byte(SYNC_BYTE_1);
            end
         endcase
      end else begin
         repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      end
   endtask

   // Drain, load all four registers (junk in unused high bits of the 8-bit ones), then run
   task automatic run_phase(input logic [7:0] t, input logic [7:0] mn, input logic [7:0] mx,
                            input logic [15:0] lim, input int budget, input bit hold);
      int          start;
      logic [15:0] junk;
      wait_drained();
      junk = 16'($urandom);
      csr_put(REG_EXPECTED_TYPE, {junk[15:8], t});
      csr_put(REG_MIN_LENGTH, {junk[7:0], mn});
      csr_put(REG_MAX_LENGTH, {~junk[15:8], mx});
      csr_put(REG_TIMEOUT_LIMIT, lim);
      csr_we <= 1'b0;
      if (hold) begin
         rsp_hold_request = 1'b1;
      end
      start = rx_sent;
      while (rx_sent - start < budget) send_frame_or_noise();
   endtask

   function automatic script_row_type rx_row(input logic [7:0] b);
      script_row_type r;
      r = '{ROW_RX, b, 1'b0, 1'b0, '0, REG_EXPECTED_TYPE, '0};
      return r;
   endfunction

   function automatic script_row_type rx_sure(input logic [7:0] b, input bit has_rsp,
                                              input result_type rsp);
      script_row_type r;
      r = '{ROW_RX, b, 1'b1, has_rsp, rsp, REG_EXPECTED_TYPE, '0};
      return r;
   endfunction

   function automatic script_row_type cfg_row(input reg_index_type idx,
                                              input logic [15:0] d);
      script_row_type r;
      r = '{ROW_CFG, 8'h00, 1'b0, 1'b0, '0, idx, d};
      return r;
   endfunction

   initial begin : stimulus
      logic [7:0] rand_min;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.rx_byte = 8'h00;
      csr_we = 1'b0;
      csr_index = REG_EXPECTED_TYPE;
      csr_wdata = '0;
      idling_on = 1'b1;
      rsp_hold_request = 1'b0;
      row_fixed = 1'b0;
      row_has_rsp = 1'b0;
      row_rsp = '0;
      rx_sent = 0;
      mismatch_count = 0;

      // Header rejects under reset settings: re-arm, type 0, type 0xF1,
      // length one below and one above the limits
      script.push_back(rx_row(SYNC_BYTE_0));
      script.push_back(rx_row(SYNC_BYTE_0));
      script.push_back(rx_row(SYNC_BYTE_1));
      script.push_back(rx_sure(8'h00, 1'b0, '0));
      script.push_back(rx_row(SYNC_BYTE_0));
      script.push_back(rx_row(SYNC_BYTE_1));
      script.push_back(rx_sure(TYPE_LIMIT, 1'b0, '0));
      script.push_back(rx_row(SYNC_BYTE_0));
      script.push_back(rx_row(SYNC_BYTE_1));
      script.push_back(rx_row(EXPECTED_TYPE_RST));
      script.push_back(rx_sure(MIN_LENGTH_RST - 8'd1, 1'b0, '0));
      script.push_back(rx_row(SYNC_BYTE_0));
      script.push_back(rx_row(SYNC_BYTE_1));
      script.push_back(rx_row(EXPECTED_TYPE_RST));
      script.push_back(rx_sure(MAX_LENGTH_RST + 8'd1, 1'b0, '0));
      // Short lengths, top type expected
      script.push_back(cfg_row(REG_EXPECTED_TYPE, 16'hA5F0));
      script.push_back(cfg_row(REG_MIN_LENGTH, 16'h5A01));
      script.push_back(cfg_row(REG_MAX_LENGTH, 16'h0002));
      // Good frame of type 0xF0, payload 00 FF, checksum EB
      script.push_back(rx_row(SYNC_BYTE_0));
      script.push_back(rx_row(SYNC_BYTE_1));
      script.push_back(rx_row(8'hF0));
      script.push_back(rx_row(8'h02));
      script.push_back(rx_sure(8'h00, 1'b1, '{KIND_PAYLOAD, 8'h00, 8'd0, 8'hF0, STATUS_OK}));
      script.push_back(rx_sure(8'hFF, 1'b1, '{KIND_PAYLOAD, 8'hFF, 8'd1, 8'hF0, STATUS_OK}));
      script.push_back(rx_sure(8'hEB, 1'b1, '{KIND_END, 8'hEB, 8'd0, 8'hF0, STATUS_OK}));
      // Type 1 and a bad checksum: checksum error reported, not type error
      script.push_back(rx_row(SYNC_BYTE_0));
      script.push_back(rx_row(SYNC_BYTE_1));
      script.push_back(rx_row(8'h01));
      script.push_back(rx_row(8'h01));
      script.push_back(rx_sure(8'hAB, 1'b1, '{KIND_PAYLOAD, 8'hAB, 8'd0, 8'h01, STATUS_OK}));
      script.push_back(rx_sure(8'h00, 1'b1, '{KIND_END, 8'h00, 8'd0, 8'h01, STATUS_SUM_ERR}));

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Walk the script; registers only change once the parser is idle
      for (int i = 0; i < script.size(); i++) begin
         if (script[i].kind == ROW_CFG) begin
            if (i == 0 || script[i - 1].kind != ROW_CFG) begin
               wait_drained();
            end
            csr_put(script[i].idx, script[i].wdata);
         end else begin
            if (i > 0 && script[i - 1].kind == ROW_CFG) begin
               csr_we <= 1'b0;
            end
            send_rx(script[i].rx, script[i].fixed, script[i].has_rsp, script[i].rsp);
         end
      end

      // Reset settings, long frames
      run_phase(EXPECTED_TYPE_RST, MIN_LENGTH_RST, MAX_LENGTH_RST, TIMEOUT_LIMIT_RST,
                250, 1'b0);
      // Short frames, widest timeout, long result hold-off to back up requests
      run_phase(8'd1, 8'd1, 8'd8, 16'hFFFF, 250, 1'b1);
      // Zero length admitted, tiny timeout cuts payloads short
      run_phase(8'd240, 8'd0, 8'd6, 16'd2, 200, 1'b0);
      // Full 255-byte payloads
      run_phase(8'($urandom_range(1, 240)), 8'd255, 8'd255, 16'hFFFF, 550, 1'b0);
      // Crossed limits reject every length
      run_phase(8'($urandom_range(1, 240)), 8'd10, 8'd5, 16'd100, 100, 1'b0);
      // Random settings
      rand_min = 8'($urandom_range(0, 12));
      run_phase(8'($urandom_range(1, 240)), rand_min, 8'($urandom_range(rand_min, 40)),
                16'($urandom_range(12, 65535)), 150, 1'b0);
      // Timeout of one, no gaps on either side
      idling_on = 1'b0;
      run_phase(EXPECTED_TYPE_RST, 8'd1, 8'd3, 16'd1, 150, 1'b0);

      wait_drained();
      if (mismatch_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
